>>> hdl/byte_ring_fifo_with_unput_top_defines.svh
// Assertion macros used by the byte ring FIFO control module.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef BYTE_RING_FIFO_WITH_UNPUT_TOP_DEFINES_SVH
`define BYTE_RING_FIFO_WITH_UNPUT_TOP_DEFINES_SVH

// The expression holds at every clock edge outside reset.
`define BRF_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// When the condition holds, the consequence holds in the next cycle.
`define BRF_ASSERT_NEXT(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/brf_pkg.sv
`timescale 1ns / 1ps
package brf_pkg;
	localparam int BYTE_W = 8;
	localparam int OP_W = 3;
	localparam int SIZE_W = 9;
	localparam int REG_SIZE = 0;

	localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
	localparam logic [OP_W-1:0] OP_POP = 3'd1;
	localparam logic [OP_W-1:0] OP_UNPUT = 3'd2;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd3;
	localparam logic [OP_W-1:0] OP_SET_RD = 3'd4;
	localparam logic [OP_W-1:0] OP_SET_WR = 3'd5;

	typedef struct packed {
		logic ok;
		logic push;
		logic pop;
		logic [SIZE_W-1:0] free;
	} brf_step_t;
endpackage

>>> hdl/brf_ctrl.sv
`timescale 1ns / 1ps
`include "byte_ring_fifo_with_unput_top_defines.svh"
module brf_ctrl import brf_pkg::*; #(
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [SIZE_W-1:0] cfg_size,
	input logic accept,
	input logic [OP_W-1:0] op,
	input logic [BYTE_W-1:0] pointer_value,
	output brf_step_t step,
	output logic [$clog2(DEPTH)-1:0] wr_addr,
	output logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [SIZE_W-1:0] size
);
	localparam int AW = $clog2(DEPTH);
	localparam int WW = ((AW > SIZE_W) ? AW : SIZE_W) + 1;
	localparam int MAX_SZ = (DEPTH < 511) ? DEPTH : 511;
	localparam int RST_SZ = (DEPTH < 256) ? DEPTH : 256;
	localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_SZ);
	localparam logic [SIZE_W-1:0] RESET_SIZE = SIZE_W'(RST_SZ);

	logic [SIZE_W-1:0] size_q;
	logic [SIZE_W-1:0] free_q;
	logic [AW-1:0] rp_q;
	logic [AW-1:0] wp_q;

	logic [AW-1:0] rp_d;
	logic [AW-1:0] wp_d;
	logic [SIZE_W-1:0] free_d;
	logic [SIZE_W-1:0] size_clamped;
	logic [WW-1:0] sz_w;
	logic [WW-1:0] rp_w;
	logic [WW-1:0] wp_w;
	logic [WW-1:0] pv_w;
	logic [WW-1:0] wp_inc;
	logic empty;
	logic full;
	logic ok;
	logic push;
	logic pop;

	function automatic logic [SIZE_W-1:0] recount(input logic [WW-1:0] r,
		input logic [WW-1:0] w, input logic [WW-1:0] s);
		logic [WW-1:0] diff;
		if (r <= w) begin
			diff = s - w + r;
		end else begin
			diff = r - w;
		end
		return diff[SIZE_W-1:0];
	endfunction

	assign sz_w = WW'(size_q);
	assign rp_w = WW'(rp_q);
	assign wp_w = WW'(wp_q);
	assign pv_w = WW'(pointer_value);
	assign wp_inc = wp_w + WW'(1);
	assign empty = (free_q == size_q);
	assign full = (free_q == '0);

	always_comb begin
		if (cfg_size == '0) begin
			size_clamped = SIZE_W'(1);
		end else if (cfg_size > MAX_SIZE) begin
			size_clamped = MAX_SIZE;
		end else begin
			size_clamped = cfg_size;
		end
	end

	always_comb begin
		rp_d = rp_q;
		wp_d = wp_q;
		free_d = free_q;
		ok = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		case (op)
			OP_PUSH: begin
				if (!full) begin
					push = 1'b1;
					ok = 1'b1;
					wp_d = (wp_inc == sz_w) ? '0 : wp_inc[AW-1:0];
					free_d = free_q - SIZE_W'(1);
				end
			end
			OP_POP: begin
				if (!empty) begin
					pop = 1'b1;
					ok = 1'b1;
					rp_d = ((rp_w + WW'(1)) == sz_w) ? '0 : AW'(rp_w + WW'(1));
					free_d = free_q + SIZE_W'(1);
				end
			end
			OP_UNPUT: begin
				if (!empty) begin
					ok = 1'b1;
					wp_d = (wp_q != '0) ? wp_q - AW'(1) : AW'(sz_w - WW'(1));
					free_d = free_q + SIZE_W'(1);
				end
			end
			OP_CLEAR: begin
				ok = 1'b1;
				rp_d = '0;
				wp_d = '0;
				free_d = size_q;
			end
			OP_SET_RD: begin
				if (pv_w < sz_w) begin
					ok = 1'b1;
					rp_d = pv_w[AW-1:0];
					free_d = recount(pv_w, wp_w, sz_w);
				end
			end
			OP_SET_WR: begin
				if (pv_w < sz_w) begin
					ok = 1'b1;
					wp_d = pv_w[AW-1:0];
					free_d = recount(rp_w, pv_w, sz_w);
				end
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= RESET_SIZE;
			free_q <= RESET_SIZE;
			rp_q <= '0;
			wp_q <= '0;
		end else if (cfg_we) begin
			size_q <= size_clamped;
			free_q <= size_clamped;
			rp_q <= '0;
			wp_q <= '0;
		end else if (accept) begin
			free_q <= free_d;
			rp_q <= rp_d;
			wp_q <= wp_d;
		end
	end

	always_comb begin
		step.ok = ok;
		step.push = accept && push;
		step.pop = pop;
		step.free = free_d;
	end

	assign wr_addr = wp_q;
	assign rd_addr = rp_q;
	assign size = size_q;

	`BRF_ASSERT_ALWAYS(a_free_bound, free_q <= size_q, "Free count exceeds ring size.")
	`BRF_ASSERT_ALWAYS(a_rp_bound, rp_w < sz_w, "Read pointer outside the ring.")
	`BRF_ASSERT_ALWAYS(a_wp_bound, wp_w < sz_w, "Write pointer outside the ring.")
	`BRF_ASSERT_NEXT(a_clear_empty, accept && !cfg_we && op == OP_CLEAR, free_q == size_q,
		"Ring not empty after a clear.")
endmodule

>>> hdl/byte_ring_fifo_with_unput_top.sv
`timescale 1ns / 1ps
// Channel   | Handshake          | Words
// ----------+--------------------+--------------------------------------------
// command   | start / busy       | op, write_byte, pointer_value
// result    | done (one cycle)   | ok, read_byte, free_count
// config    | APB psel / penable | size_in_use at byte address 0
//
// A command is taken in any cycle; busy is never raised, so one word per cycle.
// Its result appears in the cycle after the command, together with the registered store read.
// The store is a single memory with one write port and one registered read port.
// Reset clears the pointers and sets the ring size to the smaller of 256 and DEPTH.
// The result side cannot stall; done is high for exactly one cycle per command.
module byte_ring_fifo_with_unput_top import brf_pkg::*; #(
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [OP_W-1:0] op,
	input logic [BYTE_W-1:0] write_byte,
	input logic [BYTE_W-1:0] pointer_value,
	output logic done,
	output logic ok,
	output logic [BYTE_W-1:0] read_byte,
	output logic [SIZE_W-1:0] free_count,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int AW = $clog2(DEPTH);

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rd_data_s1;
	logic ok_s1;
	logic pop_s1;
	logic [SIZE_W-1:0] free_s1;
	logic done_q;

	logic accept;
	logic cfg_we;
	logic sel_size;
	brf_step_t step;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic [SIZE_W-1:0] size;

	assign busy = 1'b0;
	assign pready = 1'b1;
	assign accept = start && !busy;
	assign sel_size = (paddr[2:2] == 1'(REG_SIZE));
	assign cfg_we = psel && penable && pwrite && pready && sel_size;
	assign prdata = sel_size ? 32'(size) : '0;

	brf_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_size(pwdata[SIZE_W-1:0]),
		.accept(accept),
		.op(op),
		.pointer_value(pointer_value),
		.step(step),
		.wr_addr(wr_addr),
		.rd_addr(rd_addr),
		.size(size)
	);

	always_ff @(posedge clk) begin
		if (step.push) begin
			mem[wr_addr] <= write_byte;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		ok_s1 <= step.ok;
		pop_s1 <= step.pop;
		free_s1 <= step.free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
		end
	end

	assign done = done_q;
	assign ok = ok_s1;
	assign read_byte = pop_s1 ? rd_data_s1 : '0;
	assign free_count = free_s1;
endmodule
